FILE: rtl/isbt_pkg.sv
// Shared types and constants for the interval schedule bell timer.
// Used by isbt_seq, the top level and the testbench; no dependencies.
`default_nettype none
package isbt_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_LESSON = 2'd2;
    localparam logic [1:0] OP_BREAK  = 2'd3;

    localparam logic [1:0] PHASE_NONE   = 2'd0;
    localparam logic [1:0] PHASE_LESSON = 2'd1;
    localparam logic [1:0] PHASE_BREAK  = 2'd2;

    localparam logic [1:0] REG_START_HOUR   = 2'd0;
    localparam logic [1:0] REG_START_MINUTE = 2'd1;
    localparam logic [1:0] REG_PERIOD_COUNT = 2'd2;
    localparam logic [1:0] REG_BELL_SECONDS = 2'd3;

    localparam logic [4:0] START_HOUR_RESET   = 5'd8;
    localparam logic [5:0] START_MINUTE_RESET = 6'd30;
    localparam logic [6:0] PERIOD_COUNT_RESET = 7'd5;
    localparam logic [6:0] BELL_SECONDS_RESET = 7'd6;

    localparam logic [6:0] LESSON_DEFAULT = 7'd45;
    localparam logic [6:0] BREAK_DEFAULT  = 7'd15;
    localparam logic [6:0] DUR_MIN        = 7'd1;
    localparam logic [6:0] DUR_MAX        = 7'd99;

    localparam logic [4:0] HOUR_LAST = 5'd23;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [5:0] SEC_LAST  = 6'd59;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [5:0] set_second;
        logic [5:0] slot_index;
        logic [6:0] duration_minutes;
    } item_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [6:0]  period_number;
        logic [16:0] elapsed_seconds;
        logic [16:0] remaining_seconds;
        logic        bell_on;
    } result_t;

    typedef struct packed {
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [6:0] period_count;
        logic [6:0] bell_seconds;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/isbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module isbt_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  wire                                     clk,
    input  wire                                     we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                        wdata,
    input  wire                                     re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/isbt_span_unit.sv
// Shared adder and compare: interval end = mark + minutes * 60, and now < end.
// No dependencies.
`default_nettype none
module isbt_span_unit #(
    parameter int MW = 20
) (
    input  wire  [MW-1:0] mark,
    input  wire  [6:0]    minutes,
    input  wire  [16:0]   now,
    output logic [MW-1:0] end_time,
    output logic          less
);

    logic [12:0] span;

    // 60 * m = 64 * m - 4 * m
    assign span     = {minutes, 6'd0} - {2'd0, minutes, 4'd0} + {2'd0, minutes, 4'd0}
                      - {4'd0, minutes, 2'd0};
    assign end_time = mark + MW'(span);
    assign less     = MW'(now) < end_time;

endmodule
`default_nettype wire

FILE: rtl/isbt_seq.sv
// Sequencer: time-of-day clock, duration tables, schedule walk and result register.
// Depends on isbt_pkg, isbt_ram and isbt_span_unit.
`default_nettype none
module isbt_seq #(
    parameter int MAX_PERIODS = 64
) (
    input  wire              clk,
    input  wire              rst_n,
    input  isbt_pkg::cfg_t   cfg,
    input  wire              in_valid,
    output logic             in_ready,
    input  isbt_pkg::item_t  in_item,
    output logic             out_valid,
    input  wire              out_ready,
    output isbt_pkg::result_t out_item
);
    import isbt_pkg::*;

    localparam int AW       = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
    localparam int CW       = $clog2(MAX_PERIODS + 1);
    localparam int MARK_MAX = 31 * 3600 + 63 * 60 + MAX_PERIODS * 2 * 99 * 60;
    localparam int MW       = $clog2(MARK_MAX + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPLY  = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_LESSON = 3'd4;
    localparam logic [2:0] ST_BREAK  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]             state_reg, state_next;
    item_t                  item_reg;
    logic [4:0]             hours_reg, hours_next;
    logic [5:0]             minutes_reg, minutes_next;
    logic [5:0]             seconds_reg, seconds_next;
    logic [MAX_PERIODS-1:0] lvalid_reg, lvalid_next;
    logic [MAX_PERIODS-1:0] bvalid_reg, bvalid_next;
    logic                   lv_q_reg, bv_q_reg;
    logic [16:0]            now_reg, now_next;
    logic [MW-1:0]          mark_reg, mark_next;
    logic [MW-1:0]          end_reg, end_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   before_reg, before_next;
    logic [6:0]             number_reg, number_next;
    result_t                out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [6:0]    dur_sat;
    logic          slot_ok;
    logic [AW-1:0] waddr;
    logic          we_lesson, we_break;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [6:0]    lesson_data, break_data;
    logic [6:0]    lesson_min, break_min;
    logic [6:0]    unit_min;
    logic [MW-1:0] unit_end;
    logic          unit_less;
    logic [CW-1:0] k_inc;
    logic [MW-1:0] sub_a;
    logic [MW-1:0] elapsed_full, remaining_full;
    logic [16:0]   elapsed_val;
    logic          load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign dur_sat = (item_reg.duration_minutes < DUR_MIN) ? DUR_MIN :
                     (item_reg.duration_minutes > DUR_MAX) ? DUR_MAX :
                     item_reg.duration_minutes;
    assign slot_ok   = 32'(item_reg.slot_index) < MAX_PERIODS;
    assign waddr     = AW'(item_reg.slot_index);
    assign we_lesson = (state_reg == ST_APPLY) && (item_reg.opcode == OP_LESSON) && slot_ok;
    assign we_break  = (state_reg == ST_APPLY) && (item_reg.opcode == OP_BREAK) && slot_ok;

    assign k_inc   = CW'(k_reg + 1'b1);
    assign rd_en   = (state_reg == ST_SETUP) ||
                     ((state_reg == ST_BREAK) && !unit_less && (k_inc != count_reg));
    assign rd_addr = (state_reg == ST_SETUP) ? '0 : k_inc[AW-1:0];

    isbt_ram #(.WIDTH(7), .DEPTH(MAX_PERIODS)) u_lesson_ram (
        .clk   (clk),
        .we    (we_lesson),
        .waddr (waddr),
        .wdata (dur_sat),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (lesson_data)
    );

    isbt_ram #(.WIDTH(7), .DEPTH(MAX_PERIODS)) u_break_ram (
        .clk   (clk),
        .we    (we_break),
        .waddr (waddr),
        .wdata (dur_sat),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (break_data)
    );

    assign lesson_min = lv_q_reg ? lesson_data : LESSON_DEFAULT;
    assign break_min  = bv_q_reg ? break_data : BREAK_DEFAULT;

    always_comb
    begin
        case (state_reg)
            ST_LESSON: unit_min = lesson_min;
            ST_BREAK:  unit_min = break_min;
            default:   unit_min = 7'd0;
        endcase
    end

    isbt_span_unit #(.MW(MW)) u_span (
        .mark     (mark_reg),
        .minutes  (unit_min),
        .now      (now_reg),
        .end_time (unit_end),
        .less     (unit_less)
    );

    // result arithmetic
    assign sub_a          = before_reg ? mark_reg : end_reg;
    assign remaining_full = sub_a - MW'(now_reg);
    assign elapsed_full   = MW'(now_reg) - mark_reg;
    assign elapsed_val    = before_reg ? 17'd0 : elapsed_full[16:0];

    assign load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        hours_next     = hours_reg;
        minutes_next   = minutes_reg;
        seconds_next   = seconds_reg;
        lvalid_next    = lvalid_reg;
        bvalid_next    = bvalid_reg;
        now_next       = now_reg;
        mark_next      = mark_reg;
        end_next       = end_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        before_next    = before_reg;
        number_next    = number_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                case (item_reg.opcode)
                    OP_TICK:
                    begin
                        if (seconds_reg == SEC_LAST)
                        begin
                            seconds_next = 6'd0;
                            if (minutes_reg == MIN_LAST)
                            begin
                                minutes_next = 6'd0;
                                hours_next   = (hours_reg == HOUR_LAST) ? 5'd0 :
                                               5'(hours_reg + 1'b1);
                            end
                            else
                            begin
                                minutes_next = 6'(minutes_reg + 1'b1);
                            end
                        end
                        else
                        begin
                            seconds_next = 6'(seconds_reg + 1'b1);
                        end
                    end
                    OP_SET:
                    begin
                        hours_next   = (item_reg.set_hour > HOUR_LAST) ? HOUR_LAST :
                                       item_reg.set_hour;
                        minutes_next = (item_reg.set_minute > MIN_LAST) ? MIN_LAST :
                                       item_reg.set_minute;
                        seconds_next = (item_reg.set_second > SEC_LAST) ? SEC_LAST :
                                       item_reg.set_second;
                    end
                    OP_LESSON:
                    begin
                        if (slot_ok)
                        begin
                            lvalid_next[waddr] = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (slot_ok)
                        begin
                            bvalid_next[waddr] = 1'b1;
                        end
                    end
                endcase
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                now_next    = 17'(hours_reg) * 17'd3600 + 17'(minutes_reg) * 17'd60 +
                              17'(seconds_reg);
                mark_next   = MW'(cfg.start_hour) * MW'(3600) +
                              MW'(cfg.start_minute) * MW'(60);
                count_next  = (32'(cfg.period_count) > MAX_PERIODS) ? CW'(MAX_PERIODS) :
                              CW'(cfg.period_count);
                k_next      = '0;
                phase_next  = PHASE_NONE;
                before_next = 1'b0;
                number_next = 7'd0;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (unit_less)
                begin
                    before_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LESSON;
                end
            end
            ST_LESSON:
            begin
                if (unit_less)
                begin
                    phase_next  = PHASE_LESSON;
                    number_next = 7'(k_reg);
                    end_next    = unit_end;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    mark_next  = unit_end;
                    state_next = ST_BREAK;
                end
            end
            ST_BREAK:
            begin
                if (unit_less)
                begin
                    phase_next  = PHASE_BREAK;
                    number_next = 7'(k_reg);
                    end_next    = unit_end;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    mark_next = unit_end;
                    if (k_inc == count_reg)
                    begin
                        number_next = 7'(count_reg);
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = ST_LESSON;
                    end
                end
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    out_next.phase             = phase_reg;
                    out_next.period_number     = number_reg;
                    out_next.elapsed_seconds   = elapsed_val;
                    out_next.remaining_seconds = (before_reg || (phase_reg != PHASE_NONE)) ?
                                                 remaining_full[16:0] : 17'd0;
                    out_next.bell_on           = (phase_reg != PHASE_NONE) &&
                                                 (elapsed_val < 17'(cfg.bell_seconds));
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hours_reg     <= '0;
            minutes_reg   <= '0;
            seconds_reg   <= '0;
            lvalid_reg    <= '0;
            bvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            lvalid_reg    <= lvalid_next;
            bvalid_reg    <= bvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        if (rd_en)
        begin
            lv_q_reg <= lvalid_reg[rd_addr];
            bv_q_reg <= bvalid_reg[rd_addr];
        end
        now_reg    <= now_next;
        mark_reg   <= mark_next;
        end_reg    <= end_next;
        count_reg  <= count_next;
        k_reg      <= k_next;
        phase_reg  <= phase_next;
        before_reg <= before_next;
        number_reg <= number_next;
        out_reg    <= out_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a transaction is in progress");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LESSON || state_reg == ST_BREAK) |-> (k_reg < count_reg))
        else $error("walk index beyond period count");

    a_bell_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.phase == PHASE_NONE) |-> !out_reg.bell_on)
        else $error("bell outside lesson or break");

    a_remaining_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.phase != PHASE_NONE) |-> (out_reg.remaining_seconds != 17'd0))
        else $error("zero remaining time inside an interval");
`endif

endmodule
`default_nettype wire

FILE: rtl/interval_schedule_bell_timer_top.sv
// Each input transaction yields one result after the schedule walk; a result held by
// m_axis_tready stalls the block until it is taken. No new transaction is accepted until the
// result of the last one is loaded; the walk visits one lesson or break entry per cycle
// through the shared add/compare unit fed by the duration RAMs.
// Reset (async, active low): clock 00:00:00, registers at defaults, every table slot reads
// 45 or 15 minutes until written; valid bits replace any clearing pass.
// Top level: APB register file and stream ports; depends on isbt_pkg and isbt_seq.
`default_nettype none
module interval_schedule_bell_timer_top #(
    parameter int MAX_PERIODS = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // set_hour[4:0], set_minute[10:5], set_second[16:11], slot_index[22:17],
    // duration_minutes[29:23]
    input  wire  [31:0] s_axis_tdata,
    // opcode[1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // period_number[6:0], elapsed_seconds[23:7], remaining_seconds[40:24], bell_on[41]
    output logic [47:0] m_axis_tdata,
    // phase[1:0]
    output logic [1:0]  m_axis_tuser
);
    import isbt_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item;
    result_t out_item;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_hour   <= START_HOUR_RESET;
            cfg_reg.start_minute <= START_MINUTE_RESET;
            cfg_reg.period_count <= PERIOD_COUNT_RESET;
            cfg_reg.bell_seconds <= BELL_SECONDS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_START_HOUR:   cfg_reg.start_hour   <= pwdata[4:0];
                REG_START_MINUTE: cfg_reg.start_minute <= pwdata[5:0];
                REG_PERIOD_COUNT: cfg_reg.period_count <= pwdata[6:0];
                REG_BELL_SECONDS: cfg_reg.bell_seconds <= pwdata[6:0];
                default:          cfg_reg.start_hour   <= cfg_reg.start_hour;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_START_HOUR:   prdata = {27'd0, cfg_reg.start_hour};
            REG_START_MINUTE: prdata = {26'd0, cfg_reg.start_minute};
            REG_PERIOD_COUNT: prdata = {25'd0, cfg_reg.period_count};
            REG_BELL_SECONDS: prdata = {25'd0, cfg_reg.bell_seconds};
            default:          prdata = 32'd0;
        endcase
    end

    assign in_item.opcode           = s_axis_tuser;
    assign in_item.set_hour         = s_axis_tdata[4:0];
    assign in_item.set_minute       = s_axis_tdata[10:5];
    assign in_item.set_second       = s_axis_tdata[16:11];
    assign in_item.slot_index       = s_axis_tdata[22:17];
    assign in_item.duration_minutes = s_axis_tdata[29:23];

    isbt_seq #(.MAX_PERIODS(MAX_PERIODS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tuser = out_item.phase;
    assign m_axis_tdata = {6'd0, out_item.bell_on, out_item.remaining_seconds,
                           out_item.elapsed_seconds, out_item.period_number};

endmodule
`default_nettype wire

FILE: tb/tb_interval_schedule_bell_timer_top.sv
// Testbench for interval_schedule_bell_timer_top: a directed run at reset settings, then
// random phases under several schedule settings, all checked against an in-bench predictor.
// Depends on isbt_pkg and the block's RTL.
`default_nettype none
module tb_interval_schedule_bell_timer_top;
    import isbt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [47:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;

    interval_schedule_bell_timer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // predictor state
    int cfg_start_hour = int'(START_HOUR_RESET);
    int cfg_start_minute = int'(START_MINUTE_RESET);
    int cfg_period_count = int'(PERIOD_COUNT_RESET);
    int cfg_bell = int'(BELL_SECONDS_RESET);
    int clk_hour = 0;
    int clk_min = 0;
    int clk_sec = 0;
    int lesson_min [64];
    int recess_min [64];

    item_t   pending_items [$];
    result_t predicted_status_q [$];
    item_t   driven_item = '0;
    int      mismatches = 0;
    int      tx_gap = 0;
    int      rx_stall = 0;
    int      tx_calm = 0;
    int      rx_calm = 0;

    function automatic result_t advance_and_locate(input item_t it);
        result_t    res;
        int         mark;
        int         now;
        int         count;
        int         span;
        int         k;
        bit         found;
        logic [6:0] dur;
        res = '0;
        found = 1'b0;
        case (it.opcode)
            OP_TICK:
            begin
                clk_sec++;
                if (clk_sec >= 60)
                begin
                    clk_sec = 0;
                    clk_min++;
                    if (clk_min >= 60)
                    begin
                        clk_min = 0;
                        clk_hour++;
                        if (clk_hour >= 24)
                            clk_hour = 0;
                    end
                end
            end
            OP_SET:
            begin
                clk_hour = int'((it.set_hour > HOUR_LAST) ? HOUR_LAST : it.set_hour);
                clk_min = int'((it.set_minute > MIN_LAST) ? MIN_LAST : it.set_minute);
                clk_sec = int'((it.set_second > SEC_LAST) ? SEC_LAST : it.set_second);
            end
            default:
            begin
                dur = it.duration_minutes;
                if (dur < DUR_MIN)
                    dur = DUR_MIN;
                if (dur > DUR_MAX)
                    dur = DUR_MAX;
                if (it.opcode == OP_LESSON)
                    lesson_min[it.slot_index] = int'(dur);
                else
                    recess_min[it.slot_index] = int'(dur);
            end
        endcase
        mark = cfg_start_hour * 3600 + cfg_start_minute * 60;
        now = clk_hour * 3600 + clk_min * 60 + clk_sec;
        count = (cfg_period_count > 64) ? 64 : cfg_period_count;
        if (now < mark)
            res.remaining_seconds = 17'(mark - now);
        else
        begin
            for (k = 0; k < count && !found; k++)
            begin
                span = lesson_min[k] * 60;
                if (now < mark + span)
                begin
                    res.phase = PHASE_LESSON;
                    res.period_number = 7'(k);
                    res.elapsed_seconds = 17'(now - mark);
                    res.remaining_seconds = 17'(mark + span - now);
                    found = 1'b1;
                end
                else
                begin
                    mark += span;
                    span = recess_min[k] * 60;
                    if (now < mark + span)
                    begin
                        res.phase = PHASE_BREAK;
                        res.period_number = 7'(k);
                        res.elapsed_seconds = 17'(now - mark);
                        res.remaining_seconds = 17'(mark + span - now);
                        found = 1'b1;
                    end
                    else
                        mark += span;
                end
            end
            if (!found)
            begin
                res.phase = PHASE_NONE;
                res.period_number = 7'(count);
                res.elapsed_seconds = 17'(now - mark);
            end
        end
        res.bell_on = (res.phase != PHASE_NONE) && (int'(res.elapsed_seconds) < cfg_bell);
        return res;
    endfunction

    // start of the j-th lesson or break, counted from the schedule start
    function automatic int boundary_second(input int j);
        int b;
        int k;
        b = cfg_start_hour * 3600 + cfg_start_minute * 60;
        for (k = 0; k < j; k++)
            b += (((k % 2) == 0) ? lesson_min[k / 2] : recess_min[k / 2]) * 60;
        return b;
    endfunction

    function automatic int pick_idle(input bit rx_side);
        int r;
        if (rx_side && rx_calm > 0)
        begin
            rx_calm--;
            return 0;
        end
        if (!rx_side && tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            if (rx_side)
                rx_calm = $urandom_range(20, 80);
            else
                tx_calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_item(input logic [1:0] op, input logic [4:0] hh,
                                       input logic [5:0] mm, input logic [5:0] ss,
                                       input logic [5:0] slot, input logic [6:0] dur);
        item_t it;
        it.opcode = op;
        it.set_hour = hh;
        it.set_minute = mm;
        it.set_second = ss;
        it.slot_index = slot;
        it.duration_minutes = dur;
        pending_items.push_back(it);
    endfunction

    task automatic push_random_item();
        int r;
        int t;
        int cnt;
        r = $urandom_range(0, 99);
        cnt = (cfg_period_count > 64) ? 64 : cfg_period_count;
        if (r < 8)
            queue_item(OP_SET, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)), 6'($urandom), 7'($urandom));
        else if (r < 18)
            queue_item((r < 13) ? OP_LESSON : OP_BREAK, 5'($urandom), 6'($urandom),
                       6'($urandom), 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)));
        else if (r < 38)
        begin
            // land just before a lesson or break edge, or inside its bell window
            t = boundary_second($urandom_range(0, 2 * cnt)) + $urandom_range(0, cfg_bell + 4) - 3;
            if (t < 0 || t > 86399)
                t = $urandom_range(0, 86399);
            queue_item(OP_SET, 5'(t / 3600), 6'((t / 60) % 60), 6'(t % 60), 6'($urandom),
                       7'($urandom));
        end
        else
            queue_item(OP_TICK, 5'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
                       7'($urandom));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_START_HOUR:   cfg_start_hour = int'(value[4:0]);
            REG_START_MINUTE: cfg_start_minute = int'(value[5:0]);
            REG_PERIOD_COUNT: cfg_period_count = int'(value[6:0]);
            REG_BELL_SECONDS: cfg_bell = int'(value[6:0]);
            default:          ;
        endcase
    endtask

    task automatic wait_drained();
        do
        begin
            while (pending_items.size() != 0 || s_axis_tvalid ||
                   predicted_status_q.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
        while (pending_items.size() != 0 || s_axis_tvalid || predicted_status_q.size() != 0);
    endtask

    task automatic run_phase(input logic [4:0] sh, input logic [5:0] sm, input logic [6:0] pc,
                             input logic [6:0] bell, input bit short_table);
        int s;
        write_register(REG_START_HOUR, 32'(sh));
        write_register(REG_START_MINUTE, 32'(sm));
        write_register(REG_PERIOD_COUNT, 32'(pc));
        write_register(REG_BELL_SECONDS, 32'(bell));
        if (short_table)
        begin
            // short intervals so that the whole table fits into one day
            for (s = 0; s < 64; s++)
            begin
                queue_item(OP_LESSON, 5'($urandom), 6'($urandom), 6'($urandom), 6'(s),
                           7'($urandom_range(0, 6)));
                queue_item(OP_BREAK, 5'($urandom), 6'($urandom), 6'($urandom), 6'(s),
                           7'($urandom_range(0, 6)));
            end
        end
        repeat (60) push_random_item();
        wait_drained();
    endtask

    // input side: one transaction from the queue at a time, random gaps between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            tx_gap <= 0;
        end
        else
        begin : drive
            item_t nxt;
            if (s_axis_tvalid && s_axis_tready)
                predicted_status_q.push_back(advance_and_locate(driven_item));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    driven_item <= nxt;
                    s_axis_tdata <= {2'b00, nxt.duration_minutes, nxt.slot_index,
                                     nxt.set_second, nxt.set_minute, nxt.set_hour};
                    s_axis_tuser <= nxt.opcode;
                    s_axis_tvalid <= 1'b1;
                    tx_gap <= pick_idle(1'b0);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: random stalls, field-by-field check against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin : observe
            result_t seen;
            result_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.phase = m_axis_tuser;
                seen.period_number = m_axis_tdata[6:0];
                seen.elapsed_seconds = m_axis_tdata[23:7];
                seen.remaining_seconds = m_axis_tdata[40:24];
                seen.bell_on = m_axis_tdata[41];
                if (predicted_status_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none, actual %h", $time, seen);
                end
                else
                begin
                    want = predicted_status_q.pop_front();
                    if (seen.phase !== want.phase)
                    begin
                        mismatches++;
                        $display("%0t: phase expected %0d actual %0d",
                                 $time, want.phase, seen.phase);
                    end
                    if (seen.period_number !== want.period_number)
                    begin
                        mismatches++;
                        $display("%0t: period_number expected %0d actual %0d",
                                 $time, want.period_number, seen.period_number);
                    end
                    if (seen.elapsed_seconds !== want.elapsed_seconds)
                    begin
                        mismatches++;
                        $display("%0t: elapsed_seconds expected %0d actual %0d",
                                 $time, want.elapsed_seconds, seen.elapsed_seconds);
                    end
                    if (seen.remaining_seconds !== want.remaining_seconds)
                    begin
                        mismatches++;
                        $display("%0t: remaining_seconds expected %0d actual %0d",
                                 $time, want.remaining_seconds, seen.remaining_seconds);
                    end
                    if (seen.bell_on !== want.bell_on)
                    begin
                        mismatches++;
                        $display("%0t: bell_on expected %0d actual %0d",
                                 $time, want.bell_on, seen.bell_on);
                    end
                end
            end
            if (rx_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_stall <= pick_idle(1'b1);
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 64; i++)
        begin
            lesson_min[i] = int'(LESSON_DEFAULT);
            recess_min[i] = int'(BREAK_DEFAULT);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 08:30 start, five pairs, six-second bell
        queue_item(OP_TICK, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        queue_item(OP_SET, 5'd23, 6'd59, 6'd59, 6'd0, 7'd0);
        queue_item(OP_TICK, 5'd31, 6'd63, 6'd63, 6'd63, 7'd127);
        queue_item(OP_SET, 5'd31, 6'd63, 6'd63, 6'd0, 7'd0);
        queue_item(OP_SET, 5'd8, 6'd29, 6'd59, 6'd0, 7'd0);
        queue_item(OP_TICK, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        queue_item(OP_SET, 5'd8, 6'd30, 6'd5, 6'd0, 7'd0);
        queue_item(OP_TICK, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        queue_item(OP_SET, 5'd9, 6'd14, 6'd59, 6'd0, 7'd0);
        queue_item(OP_TICK, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        queue_item(OP_SET, 5'd13, 6'd29, 6'd59, 6'd0, 7'd0);
        queue_item(OP_TICK, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        queue_item(OP_LESSON, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        queue_item(OP_BREAK, 5'd0, 6'd0, 6'd0, 6'd63, 7'd127);
        queue_item(OP_LESSON, 5'd0, 6'd0, 6'd0, 6'd4, 7'd100);
        queue_item(OP_BREAK, 5'd0, 6'd0, 6'd0, 6'd0, 7'd99);
        queue_item(OP_LESSON, 5'd0, 6'd0, 6'd0, 6'd63, 7'd1);
        queue_item(OP_BREAK, 5'd0, 6'd0, 6'd0, 6'd31, 7'd64);
        queue_item(OP_SET, 5'd8, 6'd31, 6'd0, 6'd0, 7'd0);
        queue_item(OP_TICK, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        queue_item(OP_SET, 5'd0, 6'd0, 6'd0, 6'd0, 7'd0);
        wait_drained();

        run_phase(5'd0, 6'd0, 7'd64, 7'd99, 1'b1);
        run_phase(5'd7, 6'd45, 7'd5, 7'd6, 1'b0);
        run_phase(5'd0, 6'd0, 7'd0, 7'd0, 1'b0);       // empty schedule, silent bell
        run_phase(5'd31, 6'd63, 7'd127, 7'd127, 1'b0); // start past midnight
        run_phase(5'd23, 6'd59, 7'd1, 7'd1, 1'b0);
        run_phase(5'd12, 6'd0, 7'd127, 7'd50, 1'b1);
        run_phase(5'd6, 6'd15, 7'd3, 7'd10, 1'b0);
        run_phase(5'd8, 6'd30, 7'd5, 7'd6, 1'b0);

        repeat (150) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(12 * 3000000);
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
